/* src/mcr_pkg.sv */
`timescale 1ns / 1ps
// Package for the midpoint circle rasterizer: widths, register indexes,
// draw modes, result kinds and the step descriptor. No dependencies.
package mcr_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_W      = 14;
  localparam int DEC_W      = 16;
  localparam int CNT_W      = 11;
  localparam int RAD_W      = 11;
  localparam int THK_W      = 8;
  localparam int DASH_W     = 10;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = 3;
  localparam int DASH_STEP  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_MODE      = 3'd3,
    REG_THICKNESS = 3'd4,
    REG_DASH_LEN  = 3'd5,
    REG_GAP_LEN   = 3'd6,
    REG_COLOR     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_OUTLINE = 2'd0,
    MODE_FILLED  = 2'd1,
    MODE_THICK   = 2'd2,
    MODE_DASHED  = 2'd3
  } mode_t;

  // What one step produces
  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_CENTER = 2'd1,
    KIND_SPANS  = 2'd2,
    KIND_PIXELS = 2'd3
  } kind_t;

  // Everything the emitter needs to expand one step into its results
  typedef struct packed {
    kind_t                 kind;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] xo;
    logic [COORD_BITS-1:0] yo;
    logic [COLOR_W-1:0]    color;
  } step_t;

  // Index of the final result of a step of the given kind
  function automatic logic [IDX_W-1:0] kind_last_idx(kind_t kind);
    logic [IDX_W-1:0] res;
    case (kind)
      KIND_SPANS:  res = IDX_W'(3);
      KIND_PIXELS: res = IDX_W'(7);
      default:     res = '0;
    endcase
    return res;
  endfunction

endpackage

/* src/mcr_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the midpoint circle rasterizer:
// step input, pixel/span result and configuration write. Uses mcr_pkg.

interface mcr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink   (input valid, input start_req, output ready);
endinterface

interface mcr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mcr_pkg::OUT_W-1:0]   x_first;
  logic signed [mcr_pkg::OUT_W-1:0]   x_last;
  logic signed [mcr_pkg::OUT_W-1:0]   row;
  logic        [mcr_pkg::COLOR_W-1:0] pixel_color;
  logic                               last_of_step;
  logic                               figure_done;
  modport source (output valid, output x_first, output x_last, output row,
                  output pixel_color, output last_of_step, output figure_done,
                  input ready);
  modport sink   (input valid, input x_first, input x_last, input row,
                  input pixel_color, input last_of_step, input figure_done,
                  output ready);
endinterface

interface mcr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mcr_pkg::CFG_IDX_W-1:0]       index;
  logic [mcr_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/midpoint_circle_rasterizer.sv */
`timescale 1ns / 1ps
// Midpoint circle rasterizer top level: step engine, step descriptor and
// result emitter. Depends on mcr_pkg and the channel interfaces in mcr_if.sv.

// A start transaction latches the ring range and produces no result. Each
// step transaction runs one octant iteration at once, in the cycle it is
// accepted, and leaves a step descriptor that the emitter expands into the
// results: eight pixels (outline, thick, dashed in a dash), four spans
// (filled), one center pixel, one done result, or nothing (dashed gap).
// The emitter hands out one result per cycle while the output is not stalled,
// through a registered output; the next transaction is taken in the same
// cycle the last result of the current one moves into the output register.
// Configuration writes are always ready.
module midpoint_circle_rasterizer (
  input  logic          clk,
  input  logic          rst_n,
  mcr_in_if.sink        in_ch,
  mcr_out_if.source     out_ch,
  mcr_cfg_if.sink       cfg_ch
);

  localparam int CB = mcr_pkg::COORD_BITS;
  localparam int OW = mcr_pkg::OUT_W;
  localparam int DW = mcr_pkg::DEC_W;
  localparam int THK_W_HALF = mcr_pkg::THK_W - 1;

  // Configuration registers
  logic [CB-1:0]                  center_x_r, center_y_r;
  logic [mcr_pkg::RAD_W-1:0]      radius_r;
  mcr_pkg::mode_t                 mode_r;
  logic [mcr_pkg::THK_W-1:0]      thickness_r;
  logic [mcr_pkg::DASH_W-1:0]     dash_len_r, gap_len_r;
  logic [mcr_pkg::COLOR_W-1:0]    color_r;

  // Figure state
  logic [CB-1:0]                  x_pos_r, x_pos_nxt;
  logic [CB-1:0]                  y_pos_r, y_pos_nxt;
  logic [DW-1:0]                  decision_r, decision_nxt;
  logic [CB-1:0]                  ring_radius_r, ring_radius_nxt;
  logic [CB-1:0]                  ring_outer_r, ring_outer_nxt;
  logic [mcr_pkg::CNT_W-1:0]      dash_count_r, dash_count_nxt;
  logic                           dash_on_r, dash_on_nxt;
  logic                           busy_r, busy_nxt;

  // Step descriptor and emitter
  mcr_pkg::step_t                 desc_r, desc_nxt;
  logic                           desc_valid_r;
  logic                           desc_load;
  logic [mcr_pkg::IDX_W-1:0]      idx_r;
  logic                           in_acc, emit, emit_last;

  // Output register
  logic                           out_valid_r;
  logic [OW-1:0]                  x_first_r, x_last_r, row_r;
  logic [mcr_pkg::COLOR_W-1:0]    color_out_r;
  logic                           last_r, done_r;
  logic [OW-1:0]                  x_first_nxt, x_last_nxt, row_nxt;
  logic                           last_nxt, done_nxt;

  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_r    <= '0;
      mode_r      <= mcr_pkg::MODE_OUTLINE;
      thickness_r <= mcr_pkg::THK_W'(1);
      dash_len_r  <= mcr_pkg::DASH_W'(8);
      gap_len_r   <= mcr_pkg::DASH_W'(8);
      color_r     <= '0;
    end else if (cfg_ch.valid) begin
      case (mcr_pkg::cfg_reg_t'(cfg_ch.index))
        mcr_pkg::REG_CENTER_X:  center_x_r  <= cfg_ch.data[CB-1:0];
        mcr_pkg::REG_CENTER_Y:  center_y_r  <= cfg_ch.data[CB-1:0];
        mcr_pkg::REG_RADIUS:    radius_r    <= cfg_ch.data[mcr_pkg::RAD_W-1:0];
        mcr_pkg::REG_MODE:      mode_r      <= mcr_pkg::mode_t'(cfg_ch.data[1:0]);
        mcr_pkg::REG_THICKNESS: thickness_r <= cfg_ch.data[mcr_pkg::THK_W-1:0];
        mcr_pkg::REG_DASH_LEN:  dash_len_r  <= cfg_ch.data[mcr_pkg::DASH_W-1:0];
        mcr_pkg::REG_GAP_LEN:   gap_len_r   <= cfg_ch.data[mcr_pkg::DASH_W-1:0];
        mcr_pkg::REG_COLOR:     color_r     <= cfg_ch.data[mcr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake of the input side
  assign emit      = desc_valid_r && (!out_valid_r || out_ch.ready);
  assign emit_last = emit && (idx_r == mcr_pkg::kind_last_idx(desc_r.kind));
  assign in_ch.ready = !desc_valid_r || emit_last;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // Step engine: start, one octant iteration, ring advance
  always_comb begin
    logic [THK_W_HALF-1:0]      half;
    logic [CB-1:0]              rr, ro, y_new;
    logic [CB:0]                x_inc;
    logic [mcr_pkg::DASH_W-1:0] lim;
    logic [mcr_pkg::CNT_W-1:0]  cnt_sum;
    logic                       draw, ring_end;

    half     = '0;
    rr       = '0;
    ro       = '0;
    y_new    = y_pos_r;
    x_inc    = '0;
    lim      = '0;
    cnt_sum  = '0;
    draw     = 1'b1;
    ring_end = 1'b0;

    x_pos_nxt       = x_pos_r;
    y_pos_nxt       = y_pos_r;
    decision_nxt    = decision_r;
    ring_radius_nxt = ring_radius_r;
    ring_outer_nxt  = ring_outer_r;
    dash_count_nxt  = dash_count_r;
    dash_on_nxt     = dash_on_r;
    busy_nxt        = busy_r;

    desc_load      = 1'b0;
    desc_nxt.kind  = mcr_pkg::KIND_DONE;
    desc_nxt.cx    = center_x_r;
    desc_nxt.cy    = center_y_r;
    desc_nxt.xo    = x_pos_r;
    desc_nxt.yo    = y_pos_r;
    desc_nxt.color = color_r;

    if (in_ch.start_req) begin
      // New figure: latch the ring range
      half = thickness_r[mcr_pkg::THK_W-1:1];
      if (radius_r == '0 || (mode_r == mcr_pkg::MODE_THICK && thickness_r == '0)) begin
        rr = '0;
        ro = '0;
      end else if (mode_r == mcr_pkg::MODE_THICK) begin
        rr = (CB'(radius_r) > CB'(half)) ? CB'(radius_r) - CB'(half) : '0;
        ro = CB'(radius_r) + CB'(half);
      end else begin
        rr = CB'(radius_r);
        ro = CB'(radius_r);
      end
      ring_radius_nxt = rr;
      ring_outer_nxt  = ro;
      x_pos_nxt       = '0;
      y_pos_nxt       = rr;
      decision_nxt    = DW'(3) - (DW'(rr) << 1);
      dash_count_nxt  = '0;
      dash_on_nxt     = 1'b1;
      busy_nxt        = 1'b1;
    end else if (!busy_r) begin
      desc_load     = 1'b1;
      desc_nxt.kind = mcr_pkg::KIND_DONE;
    end else begin
      if (y_pos_r == '0) begin
        // Ring of radius zero: the center pixel alone
        desc_load     = 1'b1;
        desc_nxt.kind = mcr_pkg::KIND_CENTER;
        ring_end      = 1'b1;
      end else begin
        // Dash/gap counter
        if (mode_r == mcr_pkg::MODE_DASHED) begin
          lim     = dash_on_r ? dash_len_r : gap_len_r;
          draw    = dash_on_r;
          cnt_sum = dash_count_r + mcr_pkg::CNT_W'(mcr_pkg::DASH_STEP);
          if (cnt_sum >= mcr_pkg::CNT_W'(lim)) begin
            dash_count_nxt = '0;
            dash_on_nxt    = !dash_on_r;
          end else begin
            dash_count_nxt = cnt_sum;
          end
        end
        if (mode_r == mcr_pkg::MODE_FILLED) begin
          desc_load     = 1'b1;
          desc_nxt.kind = mcr_pkg::KIND_SPANS;
        end else if (draw) begin
          desc_load     = 1'b1;
          desc_nxt.kind = mcr_pkg::KIND_PIXELS;
        end
        // Midpoint decision update, modulo 2^16
        if (decision_r[DW-1]) begin
          decision_nxt = decision_r + (DW'(x_pos_r) << 2) + DW'(6);
        end else begin
          decision_nxt = decision_r + ((DW'(x_pos_r) - DW'(y_pos_r)) << 2) + DW'(10);
          y_new        = y_pos_r - CB'(1);
        end
        x_inc     = {1'b0, x_pos_r} + (CB+1)'(1);
        x_pos_nxt = x_inc[CB-1:0];
        y_pos_nxt = y_new;
        ring_end  = {1'b0, y_new} < x_inc;
      end
      // Next ring or end of figure
      if (ring_end) begin
        if (ring_radius_r < ring_outer_r) begin
          rr              = ring_radius_r + CB'(1);
          ring_radius_nxt = rr;
          x_pos_nxt       = '0;
          y_pos_nxt       = rr;
          decision_nxt    = DW'(3) - (DW'(rr) << 1);
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  // Figure state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r       <= '0;
      y_pos_r       <= '0;
      decision_r    <= '0;
      ring_radius_r <= '0;
      ring_outer_r  <= '0;
      dash_count_r  <= '0;
      dash_on_r     <= 1'b1;
      busy_r        <= 1'b0;
    end else if (in_acc) begin
      x_pos_r       <= x_pos_nxt;
      y_pos_r       <= y_pos_nxt;
      decision_r    <= decision_nxt;
      ring_radius_r <= ring_radius_nxt;
      ring_outer_r  <= ring_outer_nxt;
      dash_count_r  <= dash_count_nxt;
      dash_on_r     <= dash_on_nxt;
      busy_r        <= busy_nxt;
    end
  end

  // Step descriptor: loaded on a transaction with results, drained by the emitter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      idx_r        <= '0;
    end else if (in_acc && desc_load) begin
      desc_valid_r <= 1'b1;
      idx_r        <= '0;
    end else if (emit_last) begin
      desc_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + mcr_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && desc_load) begin
      desc_r <= desc_nxt;
    end
  end

  // Expand the descriptor entry at idx_r into one result
  always_comb begin
    logic [OW-1:0] cx, cy, ca, rb;
    logic          swap, col_neg, row_neg;

    swap    = 1'b0;
    col_neg = 1'b0;
    row_neg = 1'b0;
    cx      = OW'(desc_r.cx);
    cy      = OW'(desc_r.cy);

    if (desc_r.kind == mcr_pkg::KIND_SPANS) begin
      swap    = idx_r[1];
      row_neg = idx_r[0];
    end else begin
      // Octant order: (x,y) (y,x) (y,-x) (x,-y) (-x,-y) (-y,-x) (-y,x) (-x,y)
      case (idx_r)
        3'd0: begin swap = 1'b0; col_neg = 1'b0; row_neg = 1'b0; end
        3'd1: begin swap = 1'b1; col_neg = 1'b0; row_neg = 1'b0; end
        3'd2: begin swap = 1'b1; col_neg = 1'b0; row_neg = 1'b1; end
        3'd3: begin swap = 1'b0; col_neg = 1'b0; row_neg = 1'b1; end
        3'd4: begin swap = 1'b0; col_neg = 1'b1; row_neg = 1'b1; end
        3'd5: begin swap = 1'b1; col_neg = 1'b1; row_neg = 1'b1; end
        3'd6: begin swap = 1'b1; col_neg = 1'b1; row_neg = 1'b0; end
        default: begin swap = 1'b0; col_neg = 1'b1; row_neg = 1'b0; end
      endcase
    end

    ca = swap ? OW'(desc_r.yo) : OW'(desc_r.xo);
    rb = swap ? OW'(desc_r.xo) : OW'(desc_r.yo);

    x_first_nxt = '0;
    x_last_nxt  = '0;
    row_nxt     = '0;
    done_nxt    = 1'b0;
    last_nxt    = (idx_r == mcr_pkg::kind_last_idx(desc_r.kind));

    case (desc_r.kind)
      mcr_pkg::KIND_DONE: begin
        done_nxt = 1'b1;
      end
      mcr_pkg::KIND_CENTER: begin
        x_first_nxt = cx;
        x_last_nxt  = cx;
        row_nxt     = cy;
      end
      mcr_pkg::KIND_SPANS: begin
        x_first_nxt = cx - ca;
        x_last_nxt  = cx + ca;
        row_nxt     = row_neg ? cy - rb : cy + rb;
      end
      default: begin
        x_first_nxt = col_neg ? cx - ca : cx + ca;
        x_last_nxt  = x_first_nxt;
        row_nxt     = row_neg ? cy - rb : cy + rb;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      x_first_r   <= x_first_nxt;
      x_last_r    <= x_last_nxt;
      row_r       <= row_nxt;
      color_out_r <= (desc_r.kind == mcr_pkg::KIND_DONE) ? '0 : desc_r.color;
      last_r      <= last_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.x_first      = signed'(x_first_r);
  assign out_ch.x_last       = signed'(x_last_r);
  assign out_ch.row          = signed'(row_r);
  assign out_ch.pixel_color  = color_out_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.figure_done  = done_r;

  // A transaction is only taken while the descriptor is empty or draining its last result
  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && desc_valid_r) |-> emit_last)
    else $error("input accepted while step descriptor still holds results");

  // The emitter index never runs past the final result of the step
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid_r |-> (idx_r <= mcr_pkg::kind_last_idx(desc_r.kind)))
    else $error("emitter index beyond last result");

  // A result that is not the last of its step keeps the descriptor alive
  a_desc_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !emit_last) |=> desc_valid_r)
    else $error("step descriptor dropped before its last result");

  // A done result ends its step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("done result not marked last of step");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for midpoint_circle_rasterizer: a self-checking run that
// predicts every pixel and span of each step transaction and compares them
// field by field. Depends on mcr_pkg and the channel interfaces of mcr_if.sv.
module tb_top;
  import mcr_pkg::*;

  // One expected pixel, span or done result
  typedef struct {
    logic signed [OUT_W-1:0] x_first;
    logic signed [OUT_W-1:0] x_last;
    logic signed [OUT_W-1:0] row;
    logic [COLOR_W-1:0]      pixel_color;
    bit                      last_of_step;
    bit                      figure_done;
  } pixel_t;

  logic clk;
  logic rst_n;

  mcr_in_if  in_ch ();
  mcr_out_if out_ch ();
  mcr_cfg_if cfg_ch ();

  midpoint_circle_rasterizer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadow
  logic [COORD_BITS-1:0] c_cx, c_cy;
  logic [RAD_W-1:0]      c_radius;
  mode_t                 c_mode;
  logic [THK_W-1:0]      c_thick;
  logic [DASH_W-1:0]     c_dash, c_gap;
  logic [COLOR_W-1:0]    c_color;

  // Walker state of the circle being drawn
  logic [COORD_BITS-1:0] g_x, g_y, g_ring, g_outer;
  int                    g_dec;
  logic [CNT_W-1:0]      g_dash_cnt;
  bit                    g_dash_on, g_busy;

  pixel_t pending_pixels[$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  pixels_seen  = 0;
  int  done_seen    = 0;
  bit  steady       = 0;   // no random idling on either side while set
  int  hold_left    = 0;   // receiver hold-off, in cycles

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------
  function automatic void queue_pixel(int xa, int xb, int r);
    pixel_t p;
    p.x_first      = OUT_W'(xa);
    p.x_last       = OUT_W'(xb);
    p.row          = OUT_W'(r);
    p.pixel_color  = c_color;
    p.last_of_step = 1'b0;
    p.figure_done  = 1'b0;
    pending_pixels.push_back(p);
  endfunction

  function automatic void restart_ring();
    int r;
    r     = g_ring;
    g_x   = '0;
    g_y   = g_ring;
    g_dec = 3 - 2 * r;
  endfunction

  function automatic void rasterize_step(bit start);
    int     cx, cy, x, y, half, lim, n0, rad;
    bit     draw, ring_end;
    pixel_t done_px;

    // Start: latch the ring range, no result
    if (start) begin
      rad = c_radius;
      if (rad == 0 || (c_mode == MODE_THICK && c_thick == 0)) begin
        g_ring  = '0;
        g_outer = '0;
      end else if (c_mode == MODE_THICK) begin
        half    = c_thick >> 1;
        g_ring  = COORD_BITS'((rad > half) ? rad - half : 0);
        g_outer = COORD_BITS'(rad + half);
      end else begin
        g_ring  = COORD_BITS'(rad);
        g_outer = COORD_BITS'(rad);
      end
      restart_ring();
      g_dash_cnt = '0;
      g_dash_on  = 1'b1;
      g_busy     = 1'b1;
      return;
    end

    // Step with no figure active
    if (!g_busy) begin
      done_px = '{default: '0};
      done_px.last_of_step = 1'b1;
      done_px.figure_done  = 1'b1;
      pending_pixels.push_back(done_px);
      return;
    end

    n0 = pending_pixels.size();
    cx = c_cx;
    cy = c_cy;
    x  = g_x;
    y  = g_y;

    if (y == 0) begin
      queue_pixel(cx, cx, cy);
      ring_end = 1'b1;
    end else begin
      draw = 1'b1;
      if (c_mode == MODE_DASHED) begin
        lim        = g_dash_on ? int'(c_dash) : int'(c_gap);
        draw       = g_dash_on;
        g_dash_cnt = g_dash_cnt + CNT_W'(DASH_STEP);
        if (int'(g_dash_cnt) >= lim) begin
          g_dash_cnt = '0;
          g_dash_on  = !g_dash_on;
        end
      end
      if (c_mode == MODE_FILLED) begin
        queue_pixel(cx - x, cx + x, cy + y);
        queue_pixel(cx - x, cx + x, cy - y);
        queue_pixel(cx - y, cx + y, cy + x);
        queue_pixel(cx - y, cx + y, cy - x);
      end else if (draw) begin
        queue_pixel(cx + x, cx + x, cy + y);
        queue_pixel(cx + y, cx + y, cy + x);
        queue_pixel(cx + y, cx + y, cy - x);
        queue_pixel(cx + x, cx + x, cy - y);
        queue_pixel(cx - x, cx - x, cy - y);
        queue_pixel(cx - y, cx - y, cy - x);
        queue_pixel(cx - y, cx - y, cy + x);
        queue_pixel(cx - x, cx - x, cy + y);
      end
      // midpoint decision update
      if (g_dec < 0) begin
        g_dec += 4 * x + 6;
      end else begin
        g_dec += 4 * (x - y) + 10;
        y--;
      end
      x++;
      g_x      = COORD_BITS'(x);
      g_y      = COORD_BITS'(y);
      ring_end = (y < x);
    end

    // next concentric ring or figure end
    if (ring_end) begin
      if (g_ring < g_outer) begin
        g_ring = g_ring + 1'b1;
        restart_ring();
      end else begin
        g_busy = 1'b0;
      end
    end

    if (pending_pixels.size() > n0) pending_pixels[$].last_of_step = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: sample mid-cycle, transaction completes at next edge
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    pixel_t p;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          p = pending_pixels.pop_front();
          check_field("x_first", p.x_first, out_ch.x_first);
          check_field("x_last", p.x_last, out_ch.x_last);
          check_field("row", p.row, out_ch.row);
          check_field("pixel_color", p.pixel_color, out_ch.pixel_color);
          check_field("last_of_step", p.last_of_step, out_ch.last_of_step);
          check_field("figure_done", p.figure_done, out_ch.figure_done);
          if (p.figure_done) done_seen++;
          else pixels_seen++;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!steady && $urandom_range(99) < 14) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------
  task automatic send_item(bit start);
    bit hit;
    if (!steady && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start;
    do begin
      @(negedge clk);
      hit = in_ch.ready;
      @(posedge clk);
    end while (!hit);
    rasterize_step(start);
    items_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    bit hit;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(negedge clk);
      hit = cfg_ch.ready;
      @(posedge clk);
    end while (!hit);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_CENTER_X:  c_cx     = val[COORD_BITS-1:0];
      REG_CENTER_Y:  c_cy     = val[COORD_BITS-1:0];
      REG_RADIUS:    c_radius = val[RAD_W-1:0];
      REG_MODE:      c_mode   = mode_t'(val[1:0]);
      REG_THICKNESS: c_thick  = val[THK_W-1:0];
      REG_DASH_LEN:  c_dash   = val[DASH_W-1:0];
      REG_GAP_LEN:   c_gap    = val[DASH_W-1:0];
      REG_COLOR:     c_color  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, wait for every pending result, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_figure(int cx, int cy, int r, mode_t md, int t, int dash,
                            int gap, logic [31:0] color);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_MODE, 32'(md));
    write_reg(REG_THICKNESS, t);
    write_reg(REG_DASH_LEN, dash);
    write_reg(REG_GAP_LEN, gap);
    write_reg(REG_COLOR, color);
  endtask

  // Step until the figure ends (plus one done step), or until the cap
  task automatic step_until_done(int max_steps);
    int n;
    n = 0;
    while (g_busy && n < max_steps) begin
      send_item(1'b0);
      n++;
    end
    if (!g_busy) send_item(1'b0);
  endtask

  task automatic draw_figure(int max_steps);
    send_item(1'b1);
    step_until_done(max_steps);
  endtask

  // Rewrite registers mid-figure; only the live ones matter before a start
  task automatic tweak_live_regs();
    write_reg(REG_CENTER_X, $urandom_range(0, 4095));
    write_reg(REG_CENTER_Y, $urandom_range(0, 4095));
    write_reg(REG_MODE, $urandom_range(0, 3));
    write_reg(REG_DASH_LEN, $urandom_range(0, 24));
    write_reg(REG_GAP_LEN, $urandom_range(0, 24));
    write_reg(REG_RADIUS, $urandom_range(0, 2047));
    write_reg(REG_COLOR, $urandom);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_idle_steps();
    // no figure since reset: done results only
    send_item(1'b0);
    send_item(1'b0);
    settle();
  endtask

  task automatic test_basic_modes();
    set_figure(100, 200, 2, MODE_OUTLINE, 1, 8, 8, 32'h1122_3344);
    draw_figure(50);
    settle();
    set_figure(50, 60, 3, MODE_FILLED, 1, 8, 8, 32'h5566_7788);
    draw_figure(50);
    settle();
  endtask

  task automatic test_degenerate();
    // zero radius, zero thickness, and an inner ring clamped to zero
    set_figure(7, 9, 0, MODE_OUTLINE, 1, 8, 8, 32'hA5A5_5A5A);
    draw_figure(50);
    settle();
    set_figure(300, 400, 5, MODE_THICK, 0, 8, 8, 32'h0F0F_0F0F);
    draw_figure(50);
    settle();
    write_reg(REG_RADIUS, 1);
    write_reg(REG_THICKNESS, 3);
    draw_figure(50);
    settle();
  endtask

  task automatic test_dashed();
    // zero limits toggle dash/gap on every iteration
    set_figure(1000, 1000, 4, MODE_DASHED, 1, 0, 0, 32'hCAFE_0001);
    draw_figure(50);
    settle();
    write_reg(REG_DASH_LEN, 16);
    write_reg(REG_GAP_LEN, 8);
    write_reg(REG_RADIUS, 7);
    draw_figure(50);
    settle();
  endtask

  task automatic test_extremes();
    set_figure(4095, 0, 2047, MODE_THICK, 255, 1023, 1023, 32'hFFFF_FFFF);
    draw_figure(3);
    settle();
    // restart while the previous figure is still running
    set_figure(0, 4095, 2047, MODE_DASHED, 1, 1023, 0, 32'h0000_0000);
    draw_figure(3);
    settle();
  endtask

  task automatic test_live_regs();
    set_figure(2000, 2000, 8, MODE_OUTLINE, 2, 8, 8, 32'h1234_5678);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    settle();
    tweak_live_regs();
    step_until_done(40);
    settle();
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering steps
    set_figure(2048, 2048, 300, MODE_OUTLINE, 1, 8, 8, 32'hDEAD_BEEF);
    steady    = 1'b1;
    hold_left = 200;
    draw_figure(24);
    steady    = 1'b0;
    settle();
  endtask

  task automatic random_setup();
    int sel, cx, cy, r, t, dash, gap;
    sel = $urandom_range(99);
    r   = (sel < 75) ? $urandom_range(0, 8) :
          (sel < 92) ? $urandom_range(9, 40) :
          (sel < 96) ? 2047 : $urandom_range(0, 2047);
    sel = $urandom_range(99);
    t   = (sel < 70) ? $urandom_range(0, 6) :
          (sel < 85) ? $urandom_range(0, 255) : 255;
    sel = $urandom_range(99);
    cx  = (sel < 10) ? 0 : (sel < 20) ? 4095 : $urandom_range(0, 4095);
    sel = $urandom_range(99);
    cy  = (sel < 10) ? 0 : (sel < 20) ? 4095 : $urandom_range(0, 4095);
    sel = $urandom_range(99);
    dash = (sel < 70) ? $urandom_range(0, 40) : (sel < 80) ? 1023 :
           $urandom_range(0, 1023);
    sel = $urandom_range(99);
    gap  = (sel < 70) ? $urandom_range(0, 40) : (sel < 80) ? 0 :
           $urandom_range(0, 1023);
    set_figure(cx, cy, r, mode_t'($urandom_range(0, 3)), t, dash, gap, $urandom);
  endtask

  task automatic test_random();
    int goal, n_fig, cap;
    goal  = items_sent + 120;
    n_fig = 0;
    while (items_sent < goal) begin
      settle();
      random_setup();
      steady = (n_fig >= 4 && n_fig < 8);
      // stray step before the start: done result or a leftover figure
      if ($urandom_range(5) == 0) send_item(1'b0);
      cap = (c_radius > 40 || c_thick > 8) ? $urandom_range(1, 5) : 60;
      if ($urandom_range(7) == 0) cap = $urandom_range(1, 3);
      draw_figure(cap);
      if ($urandom_range(5) == 0) begin
        settle();
        tweak_live_regs();
        step_until_done($urandom_range(1, 20));
      end
      n_fig++;
    end
    steady = 1'b0;
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.start_req <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_CENTER_X;
    cfg_ch.data     <= '0;
    // shadow starts at the reset values
    c_cx = '0; c_cy = '0; c_radius = '0; c_mode = MODE_OUTLINE;
    c_thick = 8'd1; c_dash = 10'd8; c_gap = 10'd8; c_color = '0;
    g_x = '0; g_y = '0; g_dec = 0; g_ring = '0; g_outer = '0;
    g_dash_cnt = '0; g_dash_on = 1'b1; g_busy = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_steps();
    test_basic_modes();
    test_degenerate();
    test_dashed();
    test_extremes();
    test_live_regs();
    test_backpressure();
    test_random();

    $display("Covered %0d input transactions, %0d pixels/spans and %0d done results checked,",
             items_sent, pixels_seen, done_seen);
    $display("over outline, filled, thick and dashed figures incl. degenerate and stalled cases.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mcr_pkg.sv
src/mcr_if.sv
src/midpoint_circle_rasterizer.sv
test/tb_top.sv
